/* sv/foc_current_p_control_step_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FOC current step block
// Shared property templates, clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef FOC_CURRENT_P_CONTROL_STEP_DEFINES_SVH
`define FOC_CURRENT_P_CONTROL_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fcpc_pkg.sv */
// ----------------------------------------------------------------------------
// fcpc_pkg
// Types and fixed coefficients of the FOC current control step.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpc_pkg;

  typedef enum logic [2:0] {
    CFG_GAIN_P,
    CFG_ANGLE_OFFSET,
    CFG_IQ_REF_SCALE,
    CFG_ID_REF,
    CFG_OUT_SCALE
  } fcpc_cfg_idx_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [11:0] angle_offset;
    logic [11:0] iq_ref_scale;
    logic [12:0] id_ref;
    logic [15:0] out_scale;
  } fcpc_cfg_t;

  localparam logic [15:0] GAIN_P_RST       = 16'd13107;
  localparam logic [11:0] ANGLE_OFFSET_RST = 12'd550;
  localparam logic [11:0] IQ_REF_SCALE_RST = 12'd800;
  localparam logic [12:0] ID_REF_RST       = 13'd0;
  localparam logic [15:0] OUT_SCALE_RST    = 16'd20972;

  localparam logic [15:0] SIN_C1 = 16'd21024;
  localparam logic [11:0] SIN_C2 = 12'd2320;
  localparam logic [15:0] SIN_C3 = 16'd51472;
  localparam logic [15:0] SIN_MAX = 16'd32767;

  localparam logic [15:0] K_SQRT3_Q15     = 16'd28378;
  localparam logic [15:0] K_INV_SQRT3_Q15 = 16'd18919;
  localparam logic [18:0] K_RECIP3        = 19'd349526;
  localparam int          DUTY_LIM3       = 98304;
  localparam int          DUTY_BIAS       = 12582912;

endpackage

`default_nettype wire

/* sv/fcpc_fifo.sv */
// ----------------------------------------------------------------------------
// fcpc_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "foc_current_p_control_step_defines.svh"

module fcpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `FCPC_ASSERT_NOW(a_no_overflow, wr_en, !full, "fifo write while full")
  `FCPC_ASSERT_NOW(a_no_underflow, rd_en, !empty, "fifo read while empty")
  `FCPC_ASSERT_NEXT(a_write_lands, (wr_en && !rd_en), !empty, "fifo lost a write")

endmodule

`default_nettype wire

/* sv/fcpc_sine.sv */
// ----------------------------------------------------------------------------
// fcpc_sine
// Four-stage Q1.15 sine evaluator using a quarter-wave polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpc_sine #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [15:0]    value
);
  import fcpc_pkg::*;

  localparam int XW = ANGLE_BITS - 1;
  localparam logic [XW-1:0] QSZ = XW'(1) << (ANGLE_BITS - 2);

  logic [1:0]    quad;
  logic [XW-1:0] x;
  logic [15:0]   z;
  logic [31:0]   zz;
  logic [27:0]   m1;
  logic [31:0]   m2;
  logic [31:0]   m3;
  logic [16:0]   y;

  logic [15:0] z1_r, z2_1_r, z2_r, z3_r, z2_2_r, t1_r, t2_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic signed [15:0] value_r;

  always_comb begin
    quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    x    = {1'b0, angle[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      x = QSZ - x;
    end
    z  = 16'(x) << (17 - ANGLE_BITS);
    zz = z * z;
    m1 = z2_1_r * SIN_C2;
    m2 = z2_2_r * t1_r;
    m3 = z3_r * t2_r;
    y  = m3[31:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r    <= z;
      z2_1_r  <= zz[30:15];
      neg1_r  <= quad[1];
      z2_r    <= z1_r;
      z2_2_r  <= z2_1_r;
      t1_r    <= SIN_C1 - 16'(m1[27:15]);
      neg2_r  <= neg1_r;
      z3_r    <= z2_r;
      t2_r    <= SIN_C3 - m2[30:15];
      neg3_r  <= neg2_r;
      if (y > 17'(SIN_MAX)) begin
        value_r <= neg3_r ? -$signed(SIN_MAX) : $signed(SIN_MAX);
      end else begin
        value_r <= neg3_r ? -$signed(y[15:0]) : $signed(y[15:0]);
      end
    end
  end

  assign value = value_r;

endmodule

`default_nettype wire

/* sv/fcpc_front.sv */
// ----------------------------------------------------------------------------
// fcpc_front
// Input stage: forms the electrical angle and the alpha/beta current sums.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpc_front #(
  parameter int ANGLE_BITS    = 12,
  parameter int RESOLVER_BITS = 10,
  parameter int CURRENT_BITS  = 12,
  parameter int ITEM_W        = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fcpc_pkg::fcpc_cfg_t      cfg,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [RESOLVER_BITS-1:0] in_resolver_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_u_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_v_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_w_raw,
  input  logic [11:0]              in_throttle,
  output logic                     item_valid,
  input  logic                     item_ready,
  output logic [ITEM_W-1:0]        item_data
);
  import fcpc_pkg::*;

  localparam int WA  = ANGLE_BITS + RESOLVER_BITS;
  localparam int WSA = CURRENT_BITS + 2;
  localparam int WSB = CURRENT_BITS + 1;

  logic [RESOLVER_BITS-1:0]       inv;
  logic [WA-1:0]                  ang_sum;
  logic signed [CURRENT_BITS-1:0] iu, iv, iw;
  logic signed [WSA-1:0]          sa;
  logic signed [WSB-1:0]          sb;
  logic                           load;
  logic                           fr_v_r;
  logic                           fr_v_nxt;
  logic [ITEM_W-1:0]              data_r;

  always_comb begin
    inv     = ~in_resolver_raw;
    ang_sum = (WA'(inv[RESOLVER_BITS-1:2]) << (ANGLE_BITS - 7)) + WA'(cfg.angle_offset);
    iu      = {~in_current_u_raw[CURRENT_BITS-1], in_current_u_raw[CURRENT_BITS-2:0]};
    iv      = {~in_current_v_raw[CURRENT_BITS-1], in_current_v_raw[CURRENT_BITS-2:0]};
    iw      = {~in_current_w_raw[CURRENT_BITS-1], in_current_w_raw[CURRENT_BITS-2:0]};
    sa      = (WSA'(iu) <<< 1) - WSA'(iv) - WSA'(iw);
    sb      = WSB'(iv) - WSB'(iw);
  end

  assign in_full  = fr_v_r && !item_ready;
  assign load     = in_push && !in_full;
  assign fr_v_nxt = load || (fr_v_r && !item_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {ang_sum[ANGLE_BITS-1:0], sa, sb, in_throttle};
    end
  end

  assign item_valid = fr_v_r;
  assign item_data  = data_r;

endmodule

`default_nettype wire

/* sv/fcpc_back.sv */
// ----------------------------------------------------------------------------
// fcpc_back
// Pipelined Park transform, P control, inverse transforms and duty scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpc_back #(
  parameter int ANGLE_BITS   = 12,
  parameter int CURRENT_BITS = 12,
  parameter int ITEM_W       = 8,
  parameter int RES_W        = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcpc_pkg::fcpc_cfg_t cfg,
  input  logic                in_empty,
  input  logic [ITEM_W-1:0]   in_data,
  output logic                in_pop,
  input  logic                out_full,
  output logic                out_push,
  output logic [RES_W-1:0]    out_data
);
  import fcpc_pkg::*;

  localparam int NS    = 15;
  localparam int WSA   = CURRENT_BITS + 2;
  localparam int WSB   = CURRENT_BITS + 1;
  localparam int WIB   = WSB + 17;
  localparam int WACS  = WSA + 16;
  localparam int WBS   = WIB + 16;
  localparam int WNUM  = WBS + 2;
  localparam int WI    = WNUM - 15;
  localparam int WREF  = 29;
  localparam int WE    = ((WI > WREF) ? WI : WREF) + 1;
  localparam int WPD   = WE + 17;
  localparam int WD    = WE + 2;
  localparam int WPV   = WD + 16;
  localparam int WVS   = WPV + 2;
  localparam int WVA   = WVS - 15;
  localparam int WVBR  = WVA + 17;
  localparam int WVB   = WVBR + 1 - 15;
  localparam int WX    = WVB + 3;
  localparam int WP    = WX + 17;
  localparam int WN    = WP + 1;
  localparam int WQ    = WN - 23;
  localparam int WER   = WE + 1 - 15;

  logic adv;
  logic [NS:1] v_r;

  logic [ANGLE_BITS-1:0]  ang0, ang_cos0;
  logic signed [WSA-1:0]  sa0;
  logic signed [WSB-1:0]  sb0;
  logic [11:0]            thr0;
  logic signed [15:0]     sin_val, cos_val;

  logic [ANGLE_BITS-1:0]  ang_r [1:NS];
  logic signed [WSA-1:0]  sa_r  [1:4];
  logic signed [WIB-1:0]  ib_r  [1:4];
  logic [23:0]            iqr_r [1:5];
  logic signed [15:0]     sn_r  [5:8];
  logic signed [15:0]     cs_r  [5:8];
  logic signed [WACS-1:0] acs5_r, asn5_r;
  logic signed [WBS-1:0]  bsn5_r, bcs5_r;
  logic signed [WE-1:0]   ed6_r, eq6_r;
  logic signed [WPD-1:0]  pd7_r, pq7_r;
  logic signed [14:0]     errd_r [7:NS];
  logic signed [14:0]     errq_r [7:NS];
  logic signed [WD-1:0]   vd8_r, vq8_r;
  logic signed [WPV-1:0]  pvdc9_r, pvqs9_r, pvds9_r, pvqc9_r;
  logic signed [WVA-1:0]  va10_r, vb10_r, va11_r;
  logic signed [WVBR-1:0] vbr11_r;
  logic signed [WX-1:0]   x3_r [3];
  logic signed [WP-1:0]   p13_r [3];
  logic [17:0]            u14_r [3];
  logic [36:0]            p15_r [3];

  logic signed [WNUM-1:0] id_sum, iq_sum;
  logic signed [WI-1:0]   id6, iq6;
  logic signed [WE-1:0]   ed6_nxt, eq6_nxt;
  logic signed [WE:0]     ed_rnd, eq_rnd;
  logic signed [WER-1:0]  erd7, erq7;
  logic signed [14:0]     errd7_nxt, errq7_nxt;
  logic signed [WPD:0]    pd_rnd, pq_rnd;
  logic signed [WVS-1:0]  va_sum, vb_sum;
  logic signed [WVBR:0]   vbs_sum;
  logic signed [WVB-1:0]  vbs12;
  logic signed [WX-1:0]   x3_nxt [3];
  logic signed [WN-1:0]   n14 [3];
  logic signed [WQ-1:0]   q14 [3];
  logic [17:0]            u14_nxt [3];
  logic [15:0]            duty [3];

  assign adv      = !(v_r[NS] && out_full);
  assign in_pop   = adv && !in_empty;
  assign out_push = adv && v_r[NS];

  assign {ang0, sa0, sb0, thr0} = in_data;
  assign ang_cos0 = ang0 + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));

  fcpc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
    .clk   (clk),
    .en    (adv),
    .angle (ang0),
    .value (sin_val)
  );

  fcpc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk   (clk),
    .en    (adv),
    .angle (ang_cos0),
    .value (cos_val)
  );

  always_comb begin
    id_sum  = (WNUM'(acs5_r) <<< 14) + WNUM'(bsn5_r) + WNUM'(16384);
    iq_sum  = WNUM'(bcs5_r) - (WNUM'(asn5_r) <<< 14) + WNUM'(16384);
    id6     = id_sum[WNUM-1:15];
    iq6     = iq_sum[WNUM-1:15];
    ed6_nxt = WE'($signed({cfg.id_ref, 15'b0})) - WE'(id6);
    eq6_nxt = WE'($signed({1'b0, iqr_r[5], 3'b0})) - WE'(iq6);

    ed_rnd  = (WE+1)'(ed6_r) + (WE+1)'(16384);
    eq_rnd  = (WE+1)'(eq6_r) + (WE+1)'(16384);
    erd7    = ed_rnd[WE:15];
    erq7    = eq_rnd[WE:15];
    if (erd7 > WER'(16383)) begin
      errd7_nxt = 15'sd16383;
    end else if (erd7 < -WER'(16384)) begin
      errd7_nxt = -15'sd16384;
    end else begin
      errd7_nxt = 15'(erd7);
    end
    if (erq7 > WER'(16383)) begin
      errq7_nxt = 15'sd16383;
    end else if (erq7 < -WER'(16384)) begin
      errq7_nxt = -15'sd16384;
    end else begin
      errq7_nxt = 15'(erq7);
    end

    pd_rnd  = (WPD+1)'(pd7_r) + (WPD+1)'(32768);
    pq_rnd  = (WPD+1)'(pq7_r) + (WPD+1)'(32768);

    va_sum  = WVS'(pvdc9_r) - WVS'(pvqs9_r) + WVS'(16384);
    vb_sum  = WVS'(pvds9_r) + WVS'(pvqc9_r) + WVS'(16384);

    vbs_sum   = (WVBR+1)'(vbr11_r) + (WVBR+1)'(16384);
    vbs12     = vbs_sum[WVBR:15];
    x3_nxt[0] = WX'(va11_r) <<< 1;
    x3_nxt[1] = (WX'(vbs12) <<< 1) + WX'(vbs12) - WX'(va11_r);
    x3_nxt[2] = -(WX'(vbs12) <<< 1) - WX'(vbs12) - WX'(va11_r);

    for (int k = 0; k < 3; k++) begin
      n14[k] = WN'(p13_r[k]) + WN'(DUTY_BIAS);
      q14[k] = n14[k][WN-1:23];
      if (q14[k] > WQ'(DUTY_LIM3 - 1)) begin
        u14_nxt[k] = 18'(2 * DUTY_LIM3 - 1);
      end else if (q14[k] < -WQ'(DUTY_LIM3)) begin
        u14_nxt[k] = '0;
      end else begin
        u14_nxt[k] = 18'(q14[k] + WQ'(DUTY_LIM3));
      end
      duty[k] = {~p15_r[k][35], p15_r[k][34:20]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-1:1], !in_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[1] <= ang0;
      for (int k = 2; k <= NS; k++) begin
        ang_r[k] <= ang_r[k-1];
      end
      sa_r[1]  <= sa0;
      ib_r[1]  <= sb0 * $signed({1'b0, K_SQRT3_Q15});
      iqr_r[1] <= thr0 * cfg.iq_ref_scale;
      for (int k = 2; k <= 4; k++) begin
        sa_r[k] <= sa_r[k-1];
        ib_r[k] <= ib_r[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        iqr_r[k] <= iqr_r[k-1];
      end
      sn_r[5] <= sin_val;
      cs_r[5] <= cos_val;
      for (int k = 6; k <= 8; k++) begin
        sn_r[k] <= sn_r[k-1];
        cs_r[k] <= cs_r[k-1];
      end
      acs5_r <= sa_r[4] * cos_val;
      asn5_r <= sa_r[4] * sin_val;
      bsn5_r <= ib_r[4] * sin_val;
      bcs5_r <= ib_r[4] * cos_val;
      ed6_r  <= ed6_nxt;
      eq6_r  <= eq6_nxt;
      pd7_r  <= ed6_r * $signed({1'b0, cfg.gain_p});
      pq7_r  <= eq6_r * $signed({1'b0, cfg.gain_p});
      errd_r[7] <= errd7_nxt;
      errq_r[7] <= errq7_nxt;
      for (int k = 8; k <= NS; k++) begin
        errd_r[k] <= errd_r[k-1];
        errq_r[k] <= errq_r[k-1];
      end
      vd8_r   <= pd_rnd[WPD:16];
      vq8_r   <= pq_rnd[WPD:16];
      pvdc9_r <= vd8_r * cs_r[8];
      pvqs9_r <= vq8_r * sn_r[8];
      pvds9_r <= vd8_r * sn_r[8];
      pvqc9_r <= vq8_r * cs_r[8];
      va10_r  <= va_sum[WVS-1:15];
      vb10_r  <= vb_sum[WVS-1:15];
      vbr11_r <= vb10_r * $signed({1'b0, K_INV_SQRT3_Q15});
      va11_r  <= va10_r;
      for (int k = 0; k < 3; k++) begin
        x3_r[k]  <= x3_nxt[k];
        p13_r[k] <= x3_r[k] * $signed({1'b0, cfg.out_scale});
        u14_r[k] <= u14_nxt[k];
        p15_r[k] <= u14_r[k] * K_RECIP3;
      end
    end
  end

  assign out_data = {duty[0], duty[1], duty[2], errd_r[NS], errq_r[NS], ang_r[NS]};

endmodule

`default_nettype wire

/* sv/foc_current_p_control_step.sv */
// ----------------------------------------------------------------------------
// foc_current_p_control_step
// Field oriented current step: angle, Clarke/Park, P control, inverse, duty.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while in_full is low and returns one
// result per sample, in order; between acceptance and result lie the input
// register, the middle queue, the fifteen stages of the back end (one
// multiplier deep at most each) and the write into the result queue. Short
// queues sit on both sides of the back end, so a full result queue stalls
// only the pipeline and the input queue keeps taking requests until it too
// fills.
`default_nettype none

module foc_current_p_control_step #(
  parameter int ANGLE_BITS    = 12,
  parameter int RESOLVER_BITS = 10,
  parameter int CURRENT_BITS  = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [RESOLVER_BITS-1:0] in_resolver_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_u_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_v_raw,
  input  logic [CURRENT_BITS-1:0]  in_current_w_raw,
  input  logic [11:0]              in_throttle,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [15:0]       out_duty_u,
  output logic signed [15:0]       out_duty_v,
  output logic signed [15:0]       out_duty_w,
  output logic signed [14:0]       out_error_d,
  output logic signed [14:0]       out_error_q,
  output logic [ANGLE_BITS-1:0]    out_electrical_angle
);
  import fcpc_pkg::*;

  localparam int ITEM_W = ANGLE_BITS + (CURRENT_BITS + 2) + (CURRENT_BITS + 1) + 12;
  localparam int RES_W  = 48 + 30 + ANGLE_BITS;

  fcpc_cfg_t         cfg_r;
  logic              item_valid, item_ready;
  logic [ITEM_W-1:0] item_data;
  logic              mid_full, mid_empty, mid_pop;
  logic [ITEM_W-1:0] mid_data;
  logic              res_full, res_push;
  logic [RES_W-1:0]  res_data, res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= GAIN_P_RST;
      cfg_r.angle_offset <= ANGLE_OFFSET_RST;
      cfg_r.iq_ref_scale <= IQ_REF_SCALE_RST;
      cfg_r.id_ref       <= ID_REF_RST;
      cfg_r.out_scale    <= OUT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (fcpc_cfg_idx_t'(cfg_index))
        CFG_GAIN_P:       cfg_r.gain_p       <= cfg_data;
        CFG_ANGLE_OFFSET: cfg_r.angle_offset <= cfg_data[11:0];
        CFG_IQ_REF_SCALE: cfg_r.iq_ref_scale <= cfg_data[11:0];
        CFG_ID_REF:       cfg_r.id_ref       <= cfg_data[12:0];
        CFG_OUT_SCALE:    cfg_r.out_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  fcpc_front #(
    .ANGLE_BITS    (ANGLE_BITS),
    .RESOLVER_BITS (RESOLVER_BITS),
    .CURRENT_BITS  (CURRENT_BITS),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_resolver_raw  (in_resolver_raw),
    .in_current_u_raw (in_current_u_raw),
    .in_current_v_raw (in_current_v_raw),
    .in_current_w_raw (in_current_w_raw),
    .in_throttle      (in_throttle),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item_data        (item_data)
  );

  assign item_ready = !mid_full;

  fcpc_fifo #(.WIDTH(ITEM_W), .DEPTH(4)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (item_valid && !mid_full),
    .wr_data (item_data),
    .rd_en   (mid_pop),
    .rd_data (mid_data),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  fcpc_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CURRENT_BITS (CURRENT_BITS),
    .ITEM_W       (ITEM_W),
    .RES_W        (RES_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_empty (mid_empty),
    .in_data  (mid_data),
    .in_pop   (mid_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_data)
  );

  fcpc_fifo #(.WIDTH(RES_W), .DEPTH(4)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .rd_en   (out_pop && !out_empty),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign {out_duty_u, out_duty_v, out_duty_w, out_error_d, out_error_q,
          out_electrical_angle} = res_head;

endmodule

`default_nettype wire

/* tb/sv/foc_step_checker.sv */
// ----------------------------------------------------------------------------
// foc_step_checker
// Watches the configuration port and both queue sides of the FOC current
// step, computes the expected duties, errors and angle for every accepted
// request, and compares them in order with the results that are popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module foc_step_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [9:0]         in_resolver_raw,
  input  logic [11:0]        in_current_u_raw,
  input  logic [11:0]        in_current_v_raw,
  input  logic [11:0]        in_current_w_raw,
  input  logic [11:0]        in_throttle,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [15:0] out_duty_u,
  input  logic signed [15:0] out_duty_v,
  input  logic signed [15:0] out_duty_w,
  input  logic signed [14:0] out_error_d,
  input  logic signed [14:0] out_error_q,
  input  logic [11:0]        out_electrical_angle,
  output int                 n_pending,
  output int                 n_errors
);
  import fcpc_pkg::*;

  typedef struct packed {
    logic signed [15:0] duty_u;
    logic signed [15:0] duty_v;
    logic signed [15:0] duty_w;
    logic signed [14:0] error_d;
    logic signed [14:0] error_q;
    logic [11:0]        angle;
  } foc_result_t;

  logic [15:0]        gain_p;
  logic [11:0]        angle_offset;
  logic [11:0]        iq_ref_scale;
  logic signed [12:0] id_ref;
  logic [15:0]        out_scale;

  foc_result_t expected_results[$];

  function automatic longint round_div(input longint n, input longint d);
    longint t;
    longint q;
    t = n + d / 2;
    q = t / d;
    if ((t % d) != 0 && t < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sine_q15(input longint a);
    longint quad;
    longint x;
    longint z;
    longint z2;
    longint t;
    longint y;
    a = a & 4095;
    quad = a >> 10;
    x = a & 1023;
    if (quad[0]) x = 1024 - x;
    z = (x << 15) >> 10;
    z2 = (z * z) >> 15;
    t = 21024 - ((z2 * 2320) >> 15);
    t = 51472 - ((z2 * t) >> 15);
    y = (z * t) >> 15;
    if (y > 32767) y = 32767;
    return quad[1] ? -y : y;
  endfunction

  function automatic foc_result_t foc_control_step(input logic [9:0] r,
      input logic [11:0] cu, input logic [11:0] cv, input logic [11:0] cw,
      input logic [11:0] thr);
    foc_result_t res;
    longint angle, sn, cs, iu, iv, iw, ia, ib, id, iq, ed, eq;
    longint vd, vq, va, vb, vbs, d;
    longint x3[3];
    angle = ((((1023 - longint'(r)) >> 2) << 5) + longint'(angle_offset)) & 4095;
    sn = sine_q15(angle);
    cs = sine_q15(angle + 1024);
    iu = longint'(cu) - 2048;
    iv = longint'(cv) - 2048;
    iw = longint'(cw) - 2048;
    ia = (2 * iu - iv - iw) * 16384;
    ib = (iv - iw) * 28378;
    id = round_div(ia * cs + ib * sn, 32768);
    iq = round_div(ib * cs - ia * sn, 32768);
    ed = longint'(id_ref) * 32768 - id;
    eq = longint'(thr) * longint'(iq_ref_scale) * 8 - iq;
    vd = round_div(ed * longint'(gain_p), 65536);
    vq = round_div(eq * longint'(gain_p), 65536);
    va = round_div(vd * cs - vq * sn, 32768);
    vb = round_div(vd * sn + vq * cs, 32768);
    vbs = round_div(vb * 18919, 32768);
    x3[0] = 2 * va;
    x3[1] = 3 * vbs - va;
    x3[2] = -3 * vbs - va;
    d = sat(round_div(x3[0] * longint'(out_scale), 25165824), -32768, 32767);
    res.duty_u = d[15:0];
    d = sat(round_div(x3[1] * longint'(out_scale), 25165824), -32768, 32767);
    res.duty_v = d[15:0];
    d = sat(round_div(x3[2] * longint'(out_scale), 25165824), -32768, 32767);
    res.duty_w = d[15:0];
    d = sat(round_div(ed, 32768), -16384, 16383);
    res.error_d = d[14:0];
    d = sat(round_div(eq, 32768), -16384, 16383);
    res.error_q = d[14:0];
    res.angle = angle[11:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_errors = n_errors + 1;
  endtask

  initial n_errors = 0;
  assign n_pending = expected_results.size();

  always @(posedge clk) begin
    foc_result_t want;
    if (!rst_n) begin
      gain_p       <= GAIN_P_RST;
      angle_offset <= ANGLE_OFFSET_RST;
      iq_ref_scale <= IQ_REF_SCALE_RST;
      id_ref       <= ID_REF_RST;
      out_scale    <= OUT_SCALE_RST;
      expected_results.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_duty_u !== want.duty_u)
            report_mismatch("duty_u", out_duty_u, want.duty_u);
          if (out_duty_v !== want.duty_v)
            report_mismatch("duty_v", out_duty_v, want.duty_v);
          if (out_duty_w !== want.duty_w)
            report_mismatch("duty_w", out_duty_w, want.duty_w);
          if (out_error_d !== want.error_d)
            report_mismatch("error_d", out_error_d, want.error_d);
          if (out_error_q !== want.error_q)
            report_mismatch("error_q", out_error_q, want.error_q);
          if (out_electrical_angle !== want.angle)
            report_mismatch("electrical_angle", out_electrical_angle, want.angle);
        end
      end
      if (in_push && !in_full)
        expected_results.push_back(foc_control_step(in_resolver_raw, in_current_u_raw,
            in_current_v_raw, in_current_w_raw, in_throttle));
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_P:       gain_p       <= cfg_data;
          CFG_ANGLE_OFFSET: angle_offset <= cfg_data[11:0];
          CFG_IQ_REF_SCALE: iq_ref_scale <= cfg_data[11:0];
          CFG_ID_REF:       id_ref       <= cfg_data[12:0];
          CFG_OUT_SCALE:    out_scale    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the FOC current step: directed extremes, then random samples
// under several register settings, with random idling on both queue sides,
// one long receiver hold-off, and a verdict from the checker's error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fcpc_pkg::*;

  localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
  localparam int         N_PHASES      = 6;
  localparam int         N_PER_PHASE   = 213;
  localparam int         HOLD_CYCLES   = 300;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_push;
  logic               in_full;
  logic [9:0]         in_resolver_raw;
  logic [11:0]        in_current_u_raw;
  logic [11:0]        in_current_v_raw;
  logic [11:0]        in_current_w_raw;
  logic [11:0]        in_throttle;
  logic               out_empty;
  logic               out_pop;
  logic signed [15:0] out_duty_u;
  logic signed [15:0] out_duty_v;
  logic signed [15:0] out_duty_w;
  logic signed [14:0] out_error_d;
  logic signed [14:0] out_error_q;
  logic [11:0]        out_electrical_angle;
  int                 n_pending;
  int                 n_errors;
  bit                 steady;
  bit                 hold_req;

  foc_current_p_control_step i_dut (.*);

  foc_step_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random pops, one long hold-off on request.
  initial begin
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] gain, input logic [11:0] aoff,
      input logic [11:0] iqs, input logic [12:0] idr, input logic [15:0] osc);
    write_reg(CFG_GAIN_P, gain);
    write_reg(CFG_ANGLE_OFFSET, {4'($urandom_range(0, 15)), aoff});
    write_reg(CFG_IQ_REF_SCALE, {4'($urandom_range(0, 15)), iqs});
    write_reg(CFG_ID_REF, {3'($urandom_range(0, 7)), idr});
    write_reg(CFG_OUT_SCALE, osc);
  endtask

  task automatic drain;
    while (n_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic push_sample(input logic [9:0] r, input logic [11:0] cu,
      input logic [11:0] cv, input logic [11:0] cw, input logic [11:0] thr);
    bit busy;
    if (!steady) begin
      while ($urandom_range(0, 99) < 22) begin
        in_push <= 1'b0;
        @(negedge clk);
      end
    end
    in_push          <= 1'b1;
    in_resolver_raw  <= r;
    in_current_u_raw <= cu;
    in_current_v_raw <= cv;
    in_current_w_raw <= cw;
    in_throttle      <= thr;
    forever begin
      busy = in_full;
      @(posedge clk);
      @(negedge clk);
      if (!busy) break;
    end
  endtask

  function automatic logic [11:0] pick12();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_samples(input int n);
    logic [9:0] r;
    for (int k = 0; k < n; k++) begin
      r = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                     : 10'($urandom_range(0, 1023));
      push_sample(r, pick12(), pick12(), pick12(), pick12());
    end
    in_push <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_GAIN_P;
    cfg_data         = '0;
    in_push          = 1'b0;
    in_resolver_raw  = '0;
    in_current_u_raw = '0;
    in_current_v_raw = '0;
    in_current_w_raw = '0;
    in_throttle      = '0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_sample(10'd0, 12'd2048, 12'd2048, 12'd2048, 12'd0);
    push_sample(10'd1023, 12'd4095, 12'd0, 12'd0, 12'd4095);
    push_sample(10'd512, 12'd0, 12'd4095, 12'd4095, 12'd0);
    push_sample(10'd255, 12'd4095, 12'd4095, 12'd0, 12'd4095);
    push_sample(10'd768, 12'd0, 12'd0, 12'd4095, 12'd2048);
    push_sample(10'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    push_sample(10'd1022, 12'd0, 12'd0, 12'd0, 12'd0);
    in_push <= 1'b0;
    drain();

    // Extreme gain and output scale drive the duties into saturation.
    set_regs(16'hFFFF, 12'd4095, 12'd4095, 13'd4095, 16'hFFFF);
    write_reg(CFG_UNUSED_LO, 16'($urandom_range(0, 65535)));
    write_reg(CFG_UNUSED_HI, 16'($urandom_range(0, 65535)));
    push_sample(10'd0, 12'd4095, 12'd0, 12'd0, 12'd4095);
    push_sample(10'd1023, 12'd0, 12'd4095, 12'd4095, 12'd4095);
    push_sample(10'd300, 12'd0, 12'd0, 12'd4095, 12'd0);
    push_sample(10'd700, 12'd4095, 12'd4095, 12'd0, 12'd0);
    in_push <= 1'b0;
    drain();
    set_regs(16'd0, 12'd0, 12'd0, 13'h1000, 16'd0);
    push_sample(10'd0, 12'd4095, 12'd0, 12'd2048, 12'd4095);
    push_sample(10'd1023, 12'd0, 12'd4095, 12'd2048, 12'd0);
    in_push <= 1'b0;
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_regs(GAIN_P_RST, ANGLE_OFFSET_RST, IQ_REF_SCALE_RST, ID_REF_RST,
                    OUT_SCALE_RST);
        1: set_regs(16'hFFFF, 12'd4095, 12'd4095, 13'h1000, 16'hFFFF);
        2: set_regs(16'd0, 12'd0, 12'd0, 13'd4095, 16'd0);
        default: set_regs(16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                          12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)),
                          16'($urandom_range(0, 65535)));
      endcase
      steady   = (p == 3);
      hold_req = (p == 4);
      random_samples(N_PER_PHASE);
      drain();
    end
    steady = 1'b0;

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
